/* rtl/core/tmr_pkg.sv */
// ============================================================================
// tmr_pkg: shared types and constants of the tile-map collision resolver
// Field widths, register codes, reset values and the item formats that
// travel between the front end, the queue and the back end.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

package tmr_pkg;

  localparam int MAP_MAX_COLS_DEF  = 64;
  localparam int MAP_MAX_ROWS_DEF  = 64;
  localparam int TILE_PIXELS_DEF   = 32;
  localparam int FRACTION_BITS_DEF = 4;
  localparam int QUEUE_DEPTH       = 2;

  localparam int POS_W      = 16;
  localparam int DIM_W      = 13;
  localparam int MAP_W      = 7;
  localparam int CELL_W     = 6;
  localparam int IDX_W      = 8;
  localparam int BASE_W     = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 13;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BOX_WIDTH  = 2'd0,
    CFG_BOX_HEIGHT = 2'd1,
    CFG_MAP_COLS   = 2'd2,
    CFG_MAP_ROWS   = 2'd3
  } tmr_cfg_idx_t;

  localparam logic [DIM_W-1:0] BOX_WIDTH_RST  = 13'd512;
  localparam logic [DIM_W-1:0] BOX_HEIGHT_RST = 13'd512;
  localparam logic [MAP_W-1:0] MAP_COLS_RST   = 7'd64;
  localparam logic [MAP_W-1:0] MAP_ROWS_RST   = 7'd64;

  localparam logic REQ_WRITE   = 1'b0;
  localparam logic REQ_RESOLVE = 1'b1;

  typedef struct packed {
    logic [DIM_W-1:0] box_width;
    logic [DIM_W-1:0] box_height;
    logic [MAP_W-1:0] map_cols;
    logic [MAP_W-1:0] map_rows;
  } tmr_cfg_t;

  typedef struct packed {
    logic                    req_type;
    logic [CELL_W-1:0]       cell_col;
    logic [CELL_W-1:0]       cell_row;
    logic                    cell_solid;
    logic signed [POS_W-1:0] pos_x;
    logic signed [POS_W-1:0] pos_y;
  } tmr_req_t;

  // A write uses slot 0 of the column and row fields; a resolve uses both
  // slots for the left/right columns and the bottom/top rows.
  typedef struct packed {
    logic                       is_resolve;
    logic                       solid;
    logic signed [POS_W-1:0]    pos_x;
    logic signed [POS_W-1:0]    pos_y;
    logic [1:0][IDX_W-1:0]      col;
    logic [1:0][IDX_W-1:0]      row;
    logic [1:0]                 col_ok;
    logic [1:0]                 row_ok;
    logic [1:0][BASE_W-1:0]     col_base;
    logic [1:0][BASE_W-1:0]     row_base;
  } tmr_entry_t;

endpackage

`default_nettype wire

/* rtl/core/tmr_ram.sv */
// ============================================================================
// tmr_ram: generic single-port RAM
// One read or write per cycle, registered read data.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module tmr_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 4096,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             en,
  input  logic             we,
  input  logic [AW-1:0]    addr,
  input  logic [WIDTH-1:0] wdata,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end else begin
        rdata <= mem[addr];
      end
    end
  end

endmodule

`default_nettype wire

/* rtl/core/tmr_queue.sv */
// ============================================================================
// tmr_queue: short item queue between front end and back end
// Keeps items in order so that map writes and resolves stay sequenced.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module tmr_queue import tmr_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  input  tmr_entry_t push_data,
  input  logic       pop,
  output tmr_entry_t head,
  output logic       full,
  output logic       empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  tmr_entry_t    mem [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;

  function automatic logic [PW-1:0] ptr_next(input logic [PW-1:0] p);
    return (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= ptr_next(wr_ptr);
      end
      if (pop) begin
        rd_ptr <= ptr_next(rd_ptr);
      end
      if (push && !pop) begin
        count <= count + CW'(1);
      end else if (pop && !push) begin
        count <= count - CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  assign head  = mem[rd_ptr];
  assign full  = (count == CW'(DEPTH));
  assign empty = (count == '0);

endmodule

`default_nettype wire

/* rtl/core/tmr_front.sv */
// ============================================================================
// tmr_front: request front end
// Accepts items, finds the corner tiles of a resolve by division with a
// constant reciprocal, checks them against the map in use and queues them.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module tmr_front import tmr_pkg::*; #(
  parameter int MAP_MAX_COLS  = MAP_MAX_COLS_DEF,
  parameter int MAP_MAX_ROWS  = MAP_MAX_ROWS_DEF,
  parameter int TILE_PIXELS   = TILE_PIXELS_DEF,
  parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       take,
  input  tmr_req_t   req,
  input  tmr_cfg_t   cfg,
  input  logic       q_full,
  output logic       busy,
  output logic       push,
  output tmr_entry_t entry
);

  localparam int TILE_UNITS = TILE_PIXELS << FRACTION_BITS;
  localparam logic [15:0] TU16  = 16'(TILE_UNITS);
  localparam logic [16:0] TU17  = 17'(TILE_UNITS);
  localparam logic [31:0] RECIP = 32'((64'd1 << 32) / TILE_UNITS);
  localparam logic [8:0]  MAXC9 = 9'(MAP_MAX_COLS);
  localparam logic [8:0]  MAXR9 = 9'(MAP_MAX_ROWS);

  typedef enum logic [2:0] {
    F_IDLE,
    F_MUL,
    F_BASE,
    F_FIX,
    F_PUSH
  } fstate_t;

  fstate_t     state;
  tmr_req_t    req_q;
  logic        v_neg [4];
  logic [15:0] v_mag [4];
  logic [15:0] quo   [4];
  logic [15:0] base  [4];

  logic signed [16:0] x_ext;
  logic signed [16:0] y_ext;
  logic signed [16:0] v_in  [4];
  logic [47:0]        prod  [4];
  logic [31:0]        bprod [4];
  logic [16:0]        rem   [4];
  logic [8:0]         cols_eff;
  logic [8:0]         rows_eff;
  logic [8:0]         lim   [4];
  logic [3:0]         ok;
  logic               wr_ok;

  always_comb begin
    x_ext   = {req.pos_x[POS_W-1], req.pos_x};
    y_ext   = {req.pos_y[POS_W-1], req.pos_y};
    v_in[0] = x_ext;
    v_in[1] = x_ext + {4'b0000, cfg.box_width};
    v_in[2] = y_ext;
    v_in[3] = y_ext + {4'b0000, cfg.box_height};
    cols_eff = (9'(cfg.map_cols) < MAXC9) ? 9'(cfg.map_cols) : MAXC9;
    rows_eff = (9'(cfg.map_rows) < MAXR9) ? 9'(cfg.map_rows) : MAXR9;
    for (int i = 0; i < 4; i++) begin
      prod[i]  = {32'b0, v_mag[i]} * {16'b0, RECIP};
      bprod[i] = {16'b0, quo[i]} * {16'b0, TU16};
      rem[i]   = {1'b0, v_mag[i]} - {1'b0, base[i]};
      lim[i]   = (i < 2) ? cols_eff : rows_eff;
      ok[i]    = !v_neg[i] && (quo[i] < {7'b0, lim[i]});
    end
    wr_ok = (9'(req_q.cell_col) < MAXC9) && (9'(req_q.cell_row) < MAXR9);
  end

  always_comb begin
    entry.is_resolve  = (req_q.req_type == REQ_RESOLVE);
    entry.solid       = req_q.cell_solid;
    entry.pos_x       = req_q.pos_x;
    entry.pos_y       = req_q.pos_y;
    entry.col[0]      = quo[0][IDX_W-1:0];
    entry.col[1]      = quo[1][IDX_W-1:0];
    entry.row[0]      = quo[2][IDX_W-1:0];
    entry.row[1]      = quo[3][IDX_W-1:0];
    entry.col_ok      = {ok[1], ok[0]};
    entry.row_ok      = {ok[3], ok[2]};
    entry.col_base[0] = base[0];
    entry.col_base[1] = base[1];
    entry.row_base[0] = base[2];
    entry.row_base[1] = base[3];
    if (req_q.req_type == REQ_WRITE) begin
      entry.col[0]    = {2'b00, req_q.cell_col};
      entry.row[0]    = {2'b00, req_q.cell_row};
      entry.col_ok[0] = wr_ok;
    end
  end

  assign busy = (state != F_IDLE);
  assign push = (state == F_PUSH) && !q_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
    end else begin
      case (state)
        F_IDLE: begin
          if (take) begin
            req_q <= req;
            for (int i = 0; i < 4; i++) begin
              v_neg[i] <= v_in[i][16];
              v_mag[i] <= v_in[i][15:0];
            end
            state <= (req.req_type == REQ_RESOLVE) ? F_MUL : F_PUSH;
          end
        end
        F_MUL: begin
          for (int i = 0; i < 4; i++) begin
            quo[i] <= prod[i][47:32];
          end
          state <= F_BASE;
        end
        F_BASE: begin
          for (int i = 0; i < 4; i++) begin
            base[i] <= bprod[i][15:0];
          end
          state <= F_FIX;
        end
        F_FIX: begin
          for (int i = 0; i < 4; i++) begin
            if (rem[i] >= TU17) begin
              quo[i]  <= quo[i] + 16'd1;
              base[i] <= base[i] + TU16;
            end
          end
          state <= F_PUSH;
        end
        F_PUSH: begin
          if (!q_full) begin
            state <= F_IDLE;
          end
        end
        default: begin
          state <= F_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

/* rtl/core/tmr_back.sv */
// ============================================================================
// tmr_back: map store and push-out back end
// Owns the solid-tile map, clears it after reset, applies cell writes, reads
// the four corner tiles of a resolve and pushes the box out tile by tile.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module tmr_back import tmr_pkg::*; #(
  parameter int MAP_MAX_COLS  = MAP_MAX_COLS_DEF,
  parameter int MAP_MAX_ROWS  = MAP_MAX_ROWS_DEF,
  parameter int TILE_PIXELS   = TILE_PIXELS_DEF,
  parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  input  tmr_cfg_t                cfg,
  input  logic                    q_empty,
  input  tmr_entry_t              head,
  output logic                    pop,
  output logic                    clearing,
  output logic                    done,
  output logic                    collided,
  output logic signed [POS_W-1:0] new_pos_x,
  output logic signed [POS_W-1:0] new_pos_y
);

  localparam int DEPTH      = MAP_MAX_COLS * MAP_MAX_ROWS;
  localparam int AW         = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int TILE_UNITS = TILE_PIXELS << FRACTION_BITS;
  localparam int WIDE_W     = POS_W + 2;
  localparam logic signed [WIDE_W-1:0] TU_W   = WIDE_W'(TILE_UNITS);
  localparam logic signed [WIDE_W-1:0] SAT_HI = WIDE_W'(32767);
  localparam logic signed [WIDE_W-1:0] SAT_LO = -SAT_HI - WIDE_W'(1);

  typedef enum logic [2:0] {
    B_CLEAR,
    B_IDLE,
    B_READ,
    B_WAIT,
    B_PA,
    B_PB,
    B_OUT
  } bstate_t;

  bstate_t                  state;
  logic [AW-1:0]            clr_addr;
  tmr_entry_t               cur;
  logic [1:0]               rk;
  logic [1:0]               pk;
  logic                     rd_vld;
  logic [1:0]               rd_idx;
  logic [3:0]               sol;
  logic signed [WIDE_W-1:0] cx;
  logic signed [WIDE_W-1:0] cy;
  logic                     ovl;
  logic                     x_lt;
  logic                     y_lt;
  logic signed [WIDE_W-1:0] dx;
  logic signed [WIDE_W-1:0] dy;

  logic          ram_en;
  logic          ram_we;
  logic [AW-1:0] ram_addr;
  logic [0:0]    ram_wdata;
  logic [0:0]    ram_rdata;
  logic [AW-1:0] rd_addr;
  logic [AW-1:0] wr_addr;
  logic          ok_rk;
  logic          ok_cap;

  logic signed [WIDE_W-1:0] left;
  logic signed [WIDE_W-1:0] right;
  logic signed [WIDE_W-1:0] bottom;
  logic signed [WIDE_W-1:0] top;
  logic signed [WIDE_W-1:0] xw;
  logic signed [WIDE_W-1:0] yh;
  logic signed [WIDE_W-1:0] lo_x;
  logic signed [WIDE_W-1:0] hi_x;
  logic signed [WIDE_W-1:0] lo_y;
  logic signed [WIDE_W-1:0] hi_y;
  logic                     ovl_c;

  function automatic logic signed [POS_W-1:0] sat16(input logic signed [WIDE_W-1:0] v);
    logic signed [WIDE_W-1:0] c;
    c = v;
    if (c > SAT_HI) begin
      c = SAT_HI;
    end
    if (c < SAT_LO) begin
      c = SAT_LO;
    end
    return c[POS_W-1:0];
  endfunction

  tmr_ram #(
    .WIDTH (1),
    .DEPTH (DEPTH)
  ) u_map (
    .clk   (clk),
    .en    (ram_en),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  always_comb begin
    rd_addr = AW'(int'(cur.row[rk[1]]) * MAP_MAX_COLS + int'(cur.col[rk[0]]));
    wr_addr = AW'(int'(head.row[0]) * MAP_MAX_COLS + int'(head.col[0]));
    ok_rk   = cur.col_ok[rk[0]] && cur.row_ok[rk[1]];
    ok_cap  = cur.col_ok[rd_idx[0]] && cur.row_ok[rd_idx[1]];
  end

  always_comb begin
    ram_en    = 1'b0;
    ram_we    = 1'b0;
    ram_addr  = rd_addr;
    ram_wdata = 1'b0;
    case (state)
      B_CLEAR: begin
        ram_en   = 1'b1;
        ram_we   = 1'b1;
        ram_addr = clr_addr;
      end
      B_IDLE: begin
        if (!q_empty && !head.is_resolve) begin
          ram_en    = head.col_ok[0];
          ram_we    = 1'b1;
          ram_addr  = wr_addr;
          ram_wdata = head.solid;
        end
      end
      B_READ: begin
        ram_en = ok_rk;
      end
      default: begin
        ram_en = 1'b0;
      end
    endcase
  end

  always_comb begin
    left   = {{(WIDE_W-BASE_W){1'b0}}, cur.col_base[pk[0]]};
    bottom = {{(WIDE_W-BASE_W){1'b0}}, cur.row_base[pk[1]]};
    right  = left + TU_W;
    top    = bottom + TU_W;
    xw     = cx + {{(WIDE_W-DIM_W){1'b0}}, cfg.box_width};
    yh     = cy + {{(WIDE_W-DIM_W){1'b0}}, cfg.box_height};
    lo_x   = (cx > left) ? cx : left;
    hi_x   = (xw < right) ? xw : right;
    lo_y   = (cy > bottom) ? cy : bottom;
    hi_y   = (yh < top) ? yh : top;
    ovl_c  = (cx < right) && (xw > left) && (yh > bottom) && (cy < top);
  end

  assign pop      = (state == B_IDLE) && !q_empty;
  assign clearing = (state == B_CLEAR);

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= B_CLEAR;
      clr_addr <= '0;
      rd_vld   <= 1'b0;
      done     <= 1'b0;
    end else begin
      done   <= 1'b0;
      rd_vld <= (state == B_READ);
      rd_idx <= rk;
      if (rd_vld) begin
        sol[rd_idx] <= ram_rdata[0] && ok_cap;
      end
      case (state)
        B_CLEAR: begin
          clr_addr <= clr_addr + AW'(1);
          if (clr_addr == AW'(DEPTH - 1)) begin
            state <= B_IDLE;
          end
        end
        B_IDLE: begin
          if (!q_empty && head.is_resolve) begin
            cur   <= head;
            cx    <= {{(WIDE_W-POS_W){head.pos_x[POS_W-1]}}, head.pos_x};
            cy    <= {{(WIDE_W-POS_W){head.pos_y[POS_W-1]}}, head.pos_y};
            rk    <= 2'd0;
            state <= B_READ;
          end
        end
        B_READ: begin
          rk <= rk + 2'd1;
          if (rk == 2'd3) begin
            state <= B_WAIT;
          end
        end
        B_WAIT: begin
          pk    <= 2'd0;
          state <= B_PA;
        end
        B_PA: begin
          if (sol[pk]) begin
            ovl   <= ovl_c;
            dx    <= hi_x - lo_x;
            dy    <= hi_y - lo_y;
            x_lt  <= (cx < left);
            y_lt  <= (cy < bottom);
            state <= B_PB;
          end else if (pk == 2'd3) begin
            state <= B_OUT;
          end else begin
            pk <= pk + 2'd1;
          end
        end
        B_PB: begin
          if (ovl) begin
            if (dx < dy) begin
              cx <= x_lt ? (cx - dx) : (cx + dx);
            end else begin
              cy <= y_lt ? (cy - dy) : (cy + dy);
            end
          end
          if (pk == 2'd3) begin
            state <= B_OUT;
          end else begin
            pk    <= pk + 2'd1;
            state <= B_PA;
          end
        end
        B_OUT: begin
          done      <= 1'b1;
          collided  <= |sol;
          new_pos_x <= sat16(cx);
          new_pos_y <= sat16(cy);
          state     <= B_IDLE;
        end
        default: begin
          state <= B_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

/* rtl/core/tile_map_aabb_collision_resolver.sv */
// ============================================================================
// tile_map_aabb_collision_resolver: tile-map box collision resolver
// Keeps a solid-tile map and pushes an agent box out of the solid tiles
// under its four corners.
// ============================================================================
// Usage:
// An item is taken at a clock edge with start high and busy low. With
// req_type low it writes one map cell and gives no result; with req_type
// high it resolves pos_x/pos_y and gives one result. The result is shown on
// collided, new_pos_x and new_pos_y for one cycle with done high; the
// receiver must take it then. Configuration is written over cfg_valid,
// cfg_ready (always high), cfg_index and cfg_data; the user must write it
// only while no item is in work, as the block itself does not enforce this.
// The front end takes no new item until it has queued the last one, which a
// full queue holds back; a resolve first passes its reciprocal-multiply,
// base and fix division steps. The back end makes four corner reads through
// the single map port, then pushes the box out of each solid corner; a cell
// write is applied straight from the queue. A two-item queue sits between the
// two. After reset all MAP_MAX_COLS * MAP_MAX_ROWS map cells (4096 by
// default) are cleared with busy high; registers return to their defaults.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module tile_map_aabb_collision_resolver import tmr_pkg::*; #(
  parameter int MAP_MAX_COLS  = MAP_MAX_COLS_DEF,
  parameter int MAP_MAX_ROWS  = MAP_MAX_ROWS_DEF,
  parameter int TILE_PIXELS   = TILE_PIXELS_DEF,
  parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  output logic                    busy,
  input  logic                    req_type,
  input  logic [CELL_W-1:0]       cell_col,
  input  logic [CELL_W-1:0]       cell_row,
  input  logic                    cell_solid,
  input  logic signed [POS_W-1:0] pos_x,
  input  logic signed [POS_W-1:0] pos_y,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [CFG_IDX_W-1:0]    cfg_index,
  input  logic [CFG_DATA_W-1:0]   cfg_data,
  output logic                    done,
  output logic                    collided,
  output logic signed [POS_W-1:0] new_pos_x,
  output logic signed [POS_W-1:0] new_pos_y
);

  tmr_cfg_t   cfg;
  tmr_req_t   req;
  tmr_entry_t f_entry;
  tmr_entry_t q_head;
  logic       take;
  logic       f_busy;
  logic       q_push;
  logic       q_pop;
  logic       q_full;
  logic       q_empty;
  logic       clearing;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.box_width  <= BOX_WIDTH_RST;
      cfg.box_height <= BOX_HEIGHT_RST;
      cfg.map_cols   <= MAP_COLS_RST;
      cfg.map_rows   <= MAP_ROWS_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (tmr_cfg_idx_t'(cfg_index))
        CFG_BOX_WIDTH:  cfg.box_width  <= cfg_data[DIM_W-1:0];
        CFG_BOX_HEIGHT: cfg.box_height <= cfg_data[DIM_W-1:0];
        CFG_MAP_COLS:   cfg.map_cols   <= cfg_data[MAP_W-1:0];
        CFG_MAP_ROWS:   cfg.map_rows   <= cfg_data[MAP_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    req.req_type   = req_type;
    req.cell_col   = cell_col;
    req.cell_row   = cell_row;
    req.cell_solid = cell_solid;
    req.pos_x      = pos_x;
    req.pos_y      = pos_y;
  end

  assign busy = f_busy || clearing;
  assign take = start && !busy;

  tmr_front #(
    .MAP_MAX_COLS  (MAP_MAX_COLS),
    .MAP_MAX_ROWS  (MAP_MAX_ROWS),
    .TILE_PIXELS   (TILE_PIXELS),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_front (
    .clk    (clk),
    .rst    (rst),
    .take   (take),
    .req    (req),
    .cfg    (cfg),
    .q_full (q_full),
    .busy   (f_busy),
    .push   (q_push),
    .entry  (f_entry)
  );

  tmr_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (f_entry),
    .pop       (q_pop),
    .head      (q_head),
    .full      (q_full),
    .empty     (q_empty)
  );

  tmr_back #(
    .MAP_MAX_COLS  (MAP_MAX_COLS),
    .MAP_MAX_ROWS  (MAP_MAX_ROWS),
    .TILE_PIXELS   (TILE_PIXELS),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .q_empty   (q_empty),
    .head      (q_head),
    .pop       (q_pop),
    .clearing  (clearing),
    .done      (done),
    .collided  (collided),
    .new_pos_x (new_pos_x),
    .new_pos_y (new_pos_y)
  );

  a_done_single: assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("result strobe held for more than one cycle");

  a_push_room: assert property (@(posedge clk) disable iff (rst) q_push |-> !q_full)
    else $error("item queued while the queue is full");

  a_clear_once: assert property (@(posedge clk) disable iff (rst)
    $rose(clearing) |-> $past(rst))
    else $error("map clearing restarted outside reset");

endmodule

`default_nettype wire
